// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the SHA-1 compression RTL.
// Depends on nothing; included inside module bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, held off while reset is high.
`define SHA1_ASSERT(lbl, ck, rs, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) prop) else $error(msg);

// Clocked check that also holds during reset.
`define SHA1_ASSERT_ALWAYS(lbl, ck, prop, msg) \
  lbl: assert property (@(posedge ck) prop) else $error(msg);

`endif

// ===== rtl/sha1_pkg.sv =====
// Shared types, constants and rotate helpers for the SHA-1 compression block.
// Depends on nothing.
`default_nettype none

package sha1_pkg;

  localparam int unsigned NUM_ROUNDS = 80;
  localparam int unsigned NUM_WORDS  = 16;
  localparam int unsigned NUM_CV     = 5;

  localparam logic [31:0] K0 = 32'h5a827999;
  localparam logic [31:0] K1 = 32'h6ed9eba1;
  localparam logic [31:0] K2 = 32'h8f1bbcdc;
  localparam logic [31:0] K3 = 32'hca62c1d6;

  localparam logic [31:0] IV [NUM_CV] = '{
    32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
  };

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
    logic [31:0] e;
  } vars_t;

  typedef struct packed {
    logic load;
    logic step;
    logic expand;
  } sched_ctl_t;

  function automatic logic [31:0] rotl1(input logic [31:0] x);
    return {x[30:0], x[31]};
  endfunction

  function automatic logic [31:0] rotl5(input logic [31:0] x);
    return {x[26:0], x[31:27]};
  endfunction

  function automatic logic [31:0] rotl30(input logic [31:0] x);
    return {x[1:0], x[31:2]};
  endfunction

endpackage

`default_nettype wire

// ===== rtl/sha1_sched.sv =====
// Rolling 16-word message schedule window for SHA-1.
// Depends on sha1_pkg.
`default_nettype none

module sha1_sched (
  input  wire                 clk,
  input  sha1_pkg::sched_ctl_t ctl,
  input  wire [31:0]          msg_word,
  output logic [31:0]         w_cur
);
  import sha1_pkg::*;

  logic [31:0] win [NUM_WORDS];
  logic [31:0] w_new;

  assign w_new = rotl1(win[13] ^ win[8] ^ win[2] ^ win[0]);
  assign w_cur = ctl.expand ? w_new : win[0];

  // shift in a message word on load, the round word on step
  always_ff @(posedge clk) begin
    if (ctl.load || ctl.step) begin
      for (int i = 0; i < NUM_WORDS - 1; i++) begin
        win[i] <= win[i+1];
      end
      win[NUM_WORDS-1] <= ctl.load ? msg_word : w_cur;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/sha1_round.sv =====
// One SHA-1 round: round function, constant select and the five-way add.
// Depends on sha1_pkg.
`default_nettype none

module sha1_round (
  input  sha1_pkg::vars_t vars,
  input  wire [6:0]       round,
  input  wire [31:0]      w,
  output sha1_pkg::vars_t vars_next
);
  import sha1_pkg::*;

  logic [31:0] f;
  logic [31:0] k;

  always_comb begin
    if (round < 7'd20) begin
      f = (vars.b & vars.c) | (~vars.b & vars.d);
      k = K0;
    end else if (round < 7'd40) begin
      f = vars.b ^ vars.c ^ vars.d;
      k = K1;
    end else if (round < 7'd60) begin
      f = (vars.b & vars.c) | (vars.b & vars.d) | (vars.c & vars.d);
      k = K2;
    end else begin
      f = vars.b ^ vars.c ^ vars.d;
      k = K3;
    end
  end

  always_comb begin
    vars_next.a = rotl5(vars.a) + f + vars.e + k + w;
    vars_next.b = vars.a;
    vars_next.c = rotl30(vars.b);
    vars_next.d = vars.c;
    vars_next.e = vars.d;
  end

endmodule

`default_nettype wire

// ===== rtl/sha1_block_compression.sv =====
// SHA-1 block compression top: word intake, round sequencer, digest output.
// Depends on sha1_pkg, sha1_sched, sha1_round and assert_macros.svh.
//
//  channel  | handshake              | payload
//  ---------+------------------------+------------------------------------
//  input    | start & !busy          | msg_word, start_message, final_block
//  digest   | strobe (one cycle)     | digest_word, word_index, last
//
// Words 1 to 15 of a block are taken one per cycle with no busy time.
// The sixteenth word holds busy through 80 rounds in the one shared round
// unit, then through the chaining add.
// A final block then stays busy while the five digest words go out.
// Synchronous reset loads the initial chaining value and clears the word count.
// The receiver cannot stall; each digest word shows for one cycle.
`default_nettype none

module sha1_block_compression (
  input  wire         clk,
  input  wire         rst,
  input  wire         start,
  output logic        busy,
  input  wire  [31:0] msg_word,
  input  wire         start_message,
  input  wire         final_block,
  output logic        strobe,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last
);
  import sha1_pkg::*;
  `include "assert_macros.svh"

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_ROUND = 4'b0010,
    ST_ADD   = 4'b0100,
    ST_OUT   = 4'b1000
  } state_t;

  state_t      state;
  logic [3:0]  word_count;
  logic [6:0]  round;
  logic [2:0]  out_idx;
  logic        fin;
  logic [31:0] cv [NUM_CV];
  vars_t       wv;
  vars_t       wv_next;
  logic [31:0] w_cur;
  sched_ctl_t  sched_ctl;
  logic        accept;
  logic [3:0]  count_eff;

  assign busy      = (state != ST_IDLE);
  assign accept    = start && !busy;
  assign count_eff = start_message ? 4'd0 : word_count;

  always_comb begin
    sched_ctl.load   = accept;
    sched_ctl.step   = (state == ST_ROUND);
    sched_ctl.expand = (state == ST_ROUND) && (round >= 7'(NUM_WORDS));
  end

  sha1_sched u_sched (
    .clk      (clk),
    .ctl      (sched_ctl),
    .msg_word (msg_word),
    .w_cur    (w_cur)
  );

  sha1_round u_round (
    .vars      (wv),
    .round     (round),
    .w         (w_cur),
    .vars_next (wv_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      word_count <= 4'd0;
      round      <= 7'd0;
      out_idx    <= 3'd0;
      fin        <= 1'b0;
      strobe     <= 1'b0;
      for (int i = 0; i < NUM_CV; i++) begin
        cv[i] <= IV[i];
      end
    end else begin
      strobe <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (accept) begin
            if (start_message) begin
              for (int i = 0; i < NUM_CV; i++) begin
                cv[i] <= IV[i];
              end
            end
            if (count_eff == 4'd15) begin
              word_count <= 4'd0;
              round      <= 7'd0;
              fin        <= final_block;
              state      <= ST_ROUND;
            end else begin
              word_count <= count_eff + 4'd1;
            end
          end
        end
        ST_ROUND: begin
          round <= round + 7'd1;
          if (round == 7'(NUM_ROUNDS - 1)) begin
            state <= ST_ADD;
          end
        end
        ST_ADD: begin
          cv[0]   <= cv[0] + wv.a;
          cv[1]   <= cv[1] + wv.b;
          cv[2]   <= cv[2] + wv.c;
          cv[3]   <= cv[3] + wv.d;
          cv[4]   <= cv[4] + wv.e;
          out_idx <= 3'd0;
          state   <= fin ? ST_OUT : ST_IDLE;
        end
        ST_OUT: begin
          strobe  <= 1'b1;
          out_idx <= out_idx + 3'd1;
          if (out_idx == 3'(NUM_CV - 1)) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // working variables and digest payload
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && accept && count_eff == 4'd15) begin
      wv.a <= start_message ? IV[0] : cv[0];
      wv.b <= start_message ? IV[1] : cv[1];
      wv.c <= start_message ? IV[2] : cv[2];
      wv.d <= start_message ? IV[3] : cv[3];
      wv.e <= start_message ? IV[4] : cv[4];
    end else if (state == ST_ROUND) begin
      wv <= wv_next;
    end
    if (state == ST_OUT) begin
      digest_word <= cv[out_idx];
      word_index  <= out_idx;
      last        <= (out_idx == 3'(NUM_CV - 1));
    end
  end

  `SHA1_ASSERT(a_strobe_from_out, clk, rst, strobe |-> $past(state == ST_OUT), "strobe outside digest phase")
  `SHA1_ASSERT(a_digest_run, clk, rst, (strobe && word_index != 3'd0) |-> $past(strobe), "digest word run broken")
  `SHA1_ASSERT(a_round_end, clk, rst, (state == ST_ROUND && round == 7'd79) |=> (state == ST_ADD), "round loop did not end")
  `SHA1_ASSERT(a_block_go, clk, rst, (accept && !start_message && word_count == 4'd15) |=> (state == ST_ROUND), "full block did not start rounds")
  `SHA1_ASSERT_ALWAYS(a_reset_idle, clk, rst |=> (state == ST_IDLE && !strobe), "reset did not idle")

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
// Self-checking testbench for sha1_block_compression: drives 16-word blocks
// and compares every digest word against an in-bench SHA-1 compression predictor.
// Depends on sha1_pkg and the sha1_block_compression RTL.
module tb_top;
  import sha1_pkg::*;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        last;
  } digest_t;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [31:0] msg_word;
  logic        start_message;
  logic        final_block;
  logic        strobe;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last;

  logic [31:0] chain_q [NUM_CV];
  logic [31:0] window_q [NUM_WORDS];
  logic [3:0]  fill_pos;
  digest_t     digest_due [$];
  int          mismatch_count;
  int          digests_predicted;
  bit          no_idle;

  sha1_block_compression dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .msg_word      (msg_word),
    .start_message (start_message),
    .final_block   (final_block),
    .strobe        (strobe),
    .digest_word   (digest_word),
    .word_index    (word_index),
    .last          (last)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic logic [31:0] rol(input logic [31:0] x, input int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  function automatic void run_rounds();
    logic [31:0] a, b, c, d, e, f, k, w, t;
    a = chain_q[0];
    b = chain_q[1];
    c = chain_q[2];
    d = chain_q[3];
    e = chain_q[4];
    for (int r = 0; r < NUM_ROUNDS; r++) begin
      if (r >= 16) begin
        window_q[r % 16] = rol(window_q[(r + 13) % 16] ^ window_q[(r + 8) % 16] ^
                               window_q[(r + 2) % 16] ^ window_q[r % 16], 1);
      end
      w = window_q[r % 16];
      if (r < 20) begin
        f = (b & c) | (~b & d);
        k = K0;
      end else if (r < 40) begin
        f = b ^ c ^ d;
        k = K1;
      end else if (r < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = K2;
      end else begin
        f = b ^ c ^ d;
        k = K3;
      end
      t = rol(a, 5) + f + e + k + w;
      e = d;
      d = c;
      c = rol(b, 30);
      b = a;
      a = t;
    end
    chain_q[0] = chain_q[0] + a;
    chain_q[1] = chain_q[1] + b;
    chain_q[2] = chain_q[2] + c;
    chain_q[3] = chain_q[3] + d;
    chain_q[4] = chain_q[4] + e;
  endfunction

  task automatic absorb_word(input logic [31:0] w, input logic st, input logic fin);
    digest_t item;
    if (st) begin
      foreach (chain_q[i]) chain_q[i] = IV[i];
      fill_pos = 4'd0;
    end
    window_q[fill_pos] = w;
    if (fill_pos != 4'd15) begin
      fill_pos = fill_pos + 4'd1;
    end else begin
      fill_pos = 4'd0;
      run_rounds();
      if (fin) begin
        for (int i = 0; i < NUM_CV; i++) begin
          item.word = chain_q[i];
          item.idx  = 3'(i);
          item.last = (i == NUM_CV - 1);
          digest_due.push_back(item);
        end
        digests_predicted++;
      end
    end
  endtask

  task automatic send_word(input logic [31:0] w, input logic st, input logic fin);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    @(negedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start         <= 1'b1;
    msg_word      <= w;
    start_message <= st;
    final_block   <= fin;
    do @(posedge clk); while (busy);
    absorb_word(w, st, fin);
  endtask

  always @(posedge clk) begin
    digest_t want;
    digest_t got;
    if (!rst && strobe) begin
      got = {digest_word, word_index, last};
      if (digest_due.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected digest word %h idx %0d last %0b", digest_word, word_index, last);
      end else begin
        want = digest_due.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("digest mismatch: expected %h idx %0d last %0b, got %h idx %0d last %0b",
                     want.word, want.idx, want.last, digest_word, word_index, last);
        end
      end
    end
  end

  // Partial block with final flags on early words; the next test restarts it.
  task automatic test_restart_mid_block();
    send_word(32'h00000000, 1'b1, 1'b0);
    send_word(32'hffffffff, 1'b0, 1'b0);
    send_word(32'h80000000, 1'b0, 1'b1);
    send_word(32'h00000001, 1'b0, 1'b1);
  endtask

  task automatic test_extreme_block();
    logic [31:0] w;
    for (int i = 0; i < NUM_WORDS; i++) begin
      w = i[0] ? 32'h00000000 : 32'hffffffff;
      if (i == 3) w = 32'h80000000;
      if (i == 4) w = 32'h00000001;
      send_word(w, i == 0, i == 2 || i == 7 || i == NUM_WORDS - 1);
    end
  endtask

  task automatic test_random_messages(input int n_items);
    int sent;
    int blocks_left;
    bit first;
    logic st;
    logic fin;
    logic [31:0] w;
    sent = 0;
    blocks_left = 0;
    first = 1'b0;
    while (sent < n_items) begin
      if (fill_pos == 4'd0) begin
        no_idle = ($urandom_range(0, 3) == 0);
        if (blocks_left == 0) begin
          blocks_left = $urandom_range(1, 3);
          first = ($urandom_range(0, 4) != 0);
        end
      end
      st = first || ($urandom_range(0, 39) == 0);
      if (fill_pos == 4'd15)
        fin = (blocks_left == 1) ? ($urandom_range(0, 7) != 0) : ($urandom_range(0, 7) == 0);
      else
        fin = $urandom_range(0, 1);
      case ($urandom_range(0, 7))
        0: w = 32'h00000000;
        1: w = 32'hffffffff;
        default: w = $urandom;
      endcase
      if (!st && fill_pos == 4'd15) blocks_left--;
      send_word(w, st, fin);
      first = 1'b0;
      sent++;
    end
  endtask

  task automatic finish_run();
    int waited;
    @(negedge clk);
    start <= 1'b0;
    waited = 0;
    while (digest_due.size() != 0 && waited < 4000) begin
      @(posedge clk);
      waited++;
    end
    repeat (100) @(posedge clk);
    if (mismatch_count == 0 && digest_due.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    msg_word = 32'h0;
    start_message = 1'b0;
    final_block = 1'b0;
    mismatch_count = 0;
    digests_predicted = 0;
    no_idle = 1'b0;
    fill_pos = 4'd0;
    foreach (chain_q[i]) chain_q[i] = IV[i];
    foreach (window_q[i]) window_q[i] = 32'h0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_restart_mid_block();
    test_extreme_block();
    test_random_messages(250);
    finish_run();
  end
endmodule

// ===== sim.f =====
+incdir+rtl
rtl/sha1_pkg.sv
rtl/sha1_sched.sv
rtl/sha1_round.sv
rtl/sha1_block_compression.sv
dv/tb_top.sv
